[sv/glcd_line_pixel_stepper_core_assert.svh]
// ----------------------------------------------------------------------------
// Line pixel stepper assertion macros
// Clocked property shorthands used by the stepper core.
// ----------------------------------------------------------------------------
`ifndef GLCD_LINE_PIXEL_STEPPER_CORE_ASSERT_SVH
`define GLCD_LINE_PIXEL_STEPPER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GLCD_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GLCD_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/glcd_pkg.sv]
// ----------------------------------------------------------------------------
// Line pixel stepper package
// Panel geometry, datapath widths and shared structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glcd_pkg;

    // Panel geometry; columns per chip must be a power of two.
    localparam int COLUMNS_PER_CHIP = 64;
    localparam int CHIP_COUNT       = 4;
    localparam int PAGE_COUNT       = 8;
    localparam int COL_BITS         = $clog2(COLUMNS_PER_CHIP);
    localparam int X_MAX            = COLUMNS_PER_CHIP * CHIP_COUNT;
    localparam int Y_MAX            = PAGE_COUNT * 8;

    // Field widths
    localparam int XW    = 9;
    localparam int YW    = 7;
    localparam int CHIPW = 2;
    localparam int PAGEW = 3;
    localparam int COLW  = 6;
    localparam int MASKW = 8;

    // Step count L reaches 512, so one bit over the coordinate width.
    localparam int LW    = XW + 1;
    // Dividend 2*k*|d| + L stays below 2^20, quotient below 2^10.
    localparam int DVDW  = 20;
    localparam int DVSW  = LW + 1;
    localparam int QW    = 10;
    localparam int CNTW  = $clog2(QW + 1);

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic            start;
        logic [DVDW-1:0] dividend;
        logic [DVSW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic [CHIPW-1:0] chip_index;
        logic [PAGEW-1:0] page_index;
        logic [COLW-1:0]  column_index;
        logic [MASKW-1:0] bit_mask;
    } t_pix_map;

endpackage

[sv/glcd_if.sv]
// ----------------------------------------------------------------------------
// Line pixel stepper channels
// Command and pixel valid/ready channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface glcd_cmd_if;
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [glcd_pkg::XW-1:0] x_start;
    logic [glcd_pkg::YW-1:0] y_start;
    logic [glcd_pkg::XW-1:0] x_end;
    logic [glcd_pkg::YW-1:0] y_end;

    modport source (output valid, command, x_start, y_start, x_end, y_end,
                    input ready);
    modport sink   (input valid, command, x_start, y_start, x_end, y_end,
                    output ready);
endinterface

interface glcd_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      point_valid;
    logic [glcd_pkg::XW-1:0]    pixel_x;
    logic [glcd_pkg::YW-1:0]    pixel_y;
    logic [glcd_pkg::CHIPW-1:0] chip_index;
    logic [glcd_pkg::PAGEW-1:0] page_index;
    logic [glcd_pkg::COLW-1:0]  column_index;
    logic [glcd_pkg::MASKW-1:0] bit_mask;
    logic                      last_point;

    modport source (output valid, point_valid, pixel_x, pixel_y, chip_index,
                    page_index, column_index, bit_mask, last_point,
                    input ready);
    modport sink   (input valid, point_valid, pixel_x, pixel_y, chip_index,
                    page_index, column_index, bit_mask, last_point,
                    output ready);
endinterface

[sv/glcd_line_pixel_stepper_core.sv]
// ----------------------------------------------------------------------------
// Line pixel stepper core
// DDA line rasterizer with exact rounding for a multi-controller panel.
// ----------------------------------------------------------------------------
// A load beat (command 0) latches two 1-based endpoints and returns the
// start point via the EMIT state and the output register. Each step beat
// (command 1) returns the next pixel start + round(k*delta/L), ties up,
// with L = max(|dx|,|dy|)+1, so step L lands exactly on the end point and
// carries last_point. A step with no line running returns an all-zero
// beat (point_valid 0). One command is in flight at a time: a step goes
// from IDLE, where it is taken, for x and then y through MUL, a multiply
// of k by |delta|, and DIV on the shared radix-2 divider (start, 10
// quotient bits, done), then to EMIT, which hands the pixel over. A load
// or an idle step goes from IDLE straight to EMIT. The result sits in an
// output register, so the next command is taken while a finished pixel
// still waits on o_pix. pixel_x/pixel_y are raw; chip, page, column and
// mask use the pixel clamped to the panel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "glcd_line_pixel_stepper_core_assert.svh"

module glcd_line_pixel_stepper_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    glcd_cmd_if.sink          i_cmd,
    glcd_pix_if.source        o_pix
);

    // Sequencer: IDLE takes a command, MUL forms the dividend for one axis,
    // DIV waits on the shared divider, EMIT hands the pixel to the output.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    localparam int XW = glcd_pkg::XW;
    localparam int YW = glcd_pkg::YW;
    localparam int LW = glcd_pkg::LW;
    localparam int QW = glcd_pkg::QW;
    localparam int PW = LW + XW;        // k * |d|
    localparam int SW = QW + 1;         // signed add of origin and quotient

    t_state r_state, n_state;

    // Line state; deltas kept as magnitude and sign.
    logic [XW-1:0] r_org_x;
    logic [YW-1:0] r_org_y;
    logic [XW-1:0] r_dx_mag;
    logic          r_dx_neg;
    logic [YW-1:0] r_dy_mag;
    logic          r_dy_neg;
    logic [LW-1:0] r_total;
    logic [LW-1:0] r_index;
    logic          r_active;

    // Step datapath
    logic                      r_axis;     // 0: x, 1: y
    logic [glcd_pkg::DVDW-1:0] r_dvd;
    logic                      r_go;
    logic [QW-1:0]             r_qx;
    logic [XW-1:0]             r_px;
    logic [YW-1:0]             r_py;
    logic                      r_pvalid;
    logic                      r_last;

    // Output register
    logic                      r_ovalid;
    logic                      r_o_pvalid;
    logic [XW-1:0]             r_o_px;
    logic [YW-1:0]             r_o_py;
    glcd_pkg::t_pix_map        r_o_map;
    logic                      r_o_last;

    glcd_pkg::t_div_req div_req;
    glcd_pkg::t_div_rsp div_rsp;
    glcd_pkg::t_pix_map pix_map;

    logic          cmd_fire;
    logic          out_free;
    logic          ld_x_neg, ld_y_neg;
    logic [XW-1:0] ld_x_mag;
    logic [YW-1:0] ld_y_mag;
    logic [LW-1:0] ld_total;
    logic [LW-1:0] idx_next;
    logic [XW-1:0] mul_mag;
    logic          mul_neg;
    logic [PW-1:0] mul_prod;
    logic [SW-1:0] q_x_sgn, q_y_sgn;
    logic [SW-1:0] sum_x, sum_y;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_ovalid || o_pix.ready;

    // Load-time delta and step count
    always_comb begin
        ld_x_neg = (i_cmd.x_end < i_cmd.x_start);
        ld_y_neg = (i_cmd.y_end < i_cmd.y_start);
        ld_x_mag = ld_x_neg ? (i_cmd.x_start - i_cmd.x_end) : (i_cmd.x_end - i_cmd.x_start);
        ld_y_mag = ld_y_neg ? (i_cmd.y_start - i_cmd.y_end) : (i_cmd.y_end - i_cmd.y_start);
        if (ld_x_mag >= XW'(ld_y_mag)) begin
            ld_total = {1'b0, ld_x_mag} + LW'(1);
        end else begin
            ld_total = LW'(ld_y_mag) + LW'(1);
        end
    end

    assign idx_next = r_index + LW'(1);

    // Dividend for round-half-up: 2k|d| + L, less one for a negative delta
    // so that the magnitude quotient gives the floor after negation.
    assign mul_mag  = r_axis ? XW'(r_dy_mag) : r_dx_mag;
    assign mul_neg  = r_axis ? r_dy_neg : r_dx_neg;
    assign mul_prod = PW'(r_index) * PW'(mul_mag);

    assign div_req.start    = r_go;
    assign div_req.dividend = r_dvd;
    assign div_req.divisor  = {r_total, 1'b0};

    // Signed quotient added to the origin
    assign q_x_sgn = r_dx_neg ? (SW'(0) - {1'b0, r_qx}) : {1'b0, r_qx};
    assign q_y_sgn = r_dy_neg ? (SW'(0) - {1'b0, div_rsp.quotient})
                              : {1'b0, div_rsp.quotient};
    assign sum_x   = SW'(r_org_x) + q_x_sgn;
    assign sum_y   = SW'(r_org_y) + q_y_sgn;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    if (i_cmd.command == glcd_pkg::CMD_STEP && r_active
                        && r_index < r_total) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = r_axis ? S_EMIT : S_MUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_index  <= '0;
            r_total  <= '0;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (r_state == S_MUL);
            if (cmd_fire) begin
                if (i_cmd.command == glcd_pkg::CMD_LOAD) begin
                    r_active <= 1'b1;
                    r_index  <= '0;
                    r_total  <= ld_total;
                end else if (!r_active || r_index >= r_total) begin
                    r_active <= 1'b0;
                end else begin
                    r_index <= idx_next;
                    if (idx_next == r_total) begin
                        r_active <= 1'b0;
                    end
                end
            end
            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_axis <= 1'b0;
            if (i_cmd.command == glcd_pkg::CMD_LOAD) begin
                r_org_x  <= i_cmd.x_start;
                r_org_y  <= i_cmd.y_start;
                r_dx_mag <= ld_x_mag;
                r_dx_neg <= ld_x_neg;
                r_dy_mag <= ld_y_mag;
                r_dy_neg <= ld_y_neg;
                r_px     <= i_cmd.x_start;
                r_py     <= i_cmd.y_start;
                r_pvalid <= 1'b1;
                r_last   <= 1'b0;
            end else if (!r_active || r_index >= r_total) begin
                r_px     <= '0;
                r_py     <= '0;
                r_pvalid <= 1'b0;
                r_last   <= 1'b0;
            end else begin
                r_last <= (idx_next == r_total);
            end
        end
        if (r_state == S_MUL) begin
            r_dvd <= glcd_pkg::DVDW'({mul_prod, 1'b0}) + glcd_pkg::DVDW'(r_total)
                     - glcd_pkg::DVDW'(mul_neg);
        end
        if (r_state == S_DIV && div_rsp.done) begin
            if (!r_axis) begin
                r_qx   <= div_rsp.quotient;
                r_axis <= 1'b1;
            end else begin
                r_px     <= sum_x[XW-1:0];
                r_py     <= sum_y[YW-1:0];
                r_pvalid <= 1'b1;
            end
        end
        if (r_state == S_EMIT && out_free) begin
            r_o_pvalid <= r_pvalid;
            r_o_px     <= r_px;
            r_o_py     <= r_py;
            r_o_map    <= r_pvalid ? pix_map : '0;
            r_o_last   <= r_last && r_pvalid;
        end
    end

    glcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    glcd_map u_map (
        .i_px  (r_px),
        .i_py  (r_py),
        .o_map (pix_map)
    );

    assign o_pix.valid        = r_ovalid;
    assign o_pix.point_valid  = r_o_pvalid;
    assign o_pix.pixel_x      = r_o_px;
    assign o_pix.pixel_y      = r_o_py;
    assign o_pix.chip_index   = r_o_map.chip_index;
    assign o_pix.page_index   = r_o_map.page_index;
    assign o_pix.column_index = r_o_map.column_index;
    assign o_pix.bit_mask     = r_o_map.bit_mask;
    assign o_pix.last_point   = r_o_last;

    // A taken command always leaves the sequencer busy in the next cycle.
    `GLCD_AST_NXT(a_busy_after_cmd, cmd_fire, r_state != S_IDLE,
        "sequencer stayed idle after a command")

    // Divider results only arrive while the sequencer waits for them.
    `GLCD_AST_IMP(a_div_done_in_div, div_rsp.done, r_state == S_DIV,
        "divider finished outside the divide state")

    // A pixel beat carries exactly one mask bit.
    `GLCD_AST_IMP(a_mask_onehot, r_ovalid && r_o_pvalid, $onehot(r_o_map.bit_mask),
        "pixel beat without a one-hot mask")

    // An idle beat is all zero in mask and last flag.
    `GLCD_AST_IMP(a_idle_beat_clear, r_ovalid && !r_o_pvalid,
        r_o_map.bit_mask == '0 && !r_o_last,
        "idle beat carries pixel fields")

endmodule

[sv/glcd_div.sv]
// ----------------------------------------------------------------------------
// Line pixel stepper divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glcd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  glcd_pkg::t_div_req i_req,
    output glcd_pkg::t_div_rsp o_rsp
);

    logic [glcd_pkg::DVSW-1:0] r_rem, n_rem;
    logic [glcd_pkg::QW-1:0]   r_quo, n_quo;
    logic [glcd_pkg::DVSW-1:0] r_dvs;
    logic [glcd_pkg::CNTW-1:0] r_cnt, n_cnt;
    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [glcd_pkg::DVSW-1:0] trial;
    logic                      ge;

    // Caller guarantees dividend < divisor * 2^QW, so the high part
    // already sits below the divisor.
    assign trial = {r_rem[glcd_pkg::DVSW-2:0], r_quo[glcd_pkg::QW-1]};
    assign ge    = (trial >= r_dvs);

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = {1'b0, i_req.dividend[glcd_pkg::DVDW-1:glcd_pkg::QW]};
            n_quo  = i_req.dividend[glcd_pkg::QW-1:0];
            n_cnt  = glcd_pkg::CNTW'(glcd_pkg::QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? (trial - r_dvs) : trial;
            n_quo = {r_quo[glcd_pkg::QW-2:0], ge};
            n_cnt = r_cnt - glcd_pkg::CNTW'(1);
            if (r_cnt == glcd_pkg::CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[sv/glcd_map.sv]
// ----------------------------------------------------------------------------
// Line pixel stepper panel map
// Clamps a pixel to the panel and splits it into chip, page, column, mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glcd_map (
    input  logic [glcd_pkg::XW-1:0] i_px,
    input  logic [glcd_pkg::YW-1:0] i_py,
    output glcd_pkg::t_pix_map      o_map
);

    localparam int XCW = glcd_pkg::XW + 2;
    localparam int YCW = glcd_pkg::YW + 1;

    logic [XCW-1:0] xc;
    logic [XCW-1:0] ux;
    logic [YCW-1:0] yc;
    logic [YCW-1:0] uy;

    always_comb begin
        if (i_px == '0) begin
            xc = XCW'(1);
        end else if ({2'b00, i_px} > XCW'(glcd_pkg::X_MAX)) begin
            xc = XCW'(glcd_pkg::X_MAX);
        end else begin
            xc = {2'b00, i_px};
        end

        if (i_py == '0) begin
            yc = YCW'(1);
        end else if ({1'b0, i_py} > YCW'(glcd_pkg::Y_MAX)) begin
            yc = YCW'(glcd_pkg::Y_MAX);
        end else begin
            yc = {1'b0, i_py};
        end

        ux = xc - XCW'(1);
        uy = yc - YCW'(1);

        o_map.chip_index   = glcd_pkg::CHIPW'(ux >> glcd_pkg::COL_BITS);
        o_map.column_index = glcd_pkg::COLW'(ux & XCW'(glcd_pkg::COLUMNS_PER_CHIP - 1));
        o_map.page_index   = glcd_pkg::PAGEW'(uy >> 3);
        o_map.bit_mask     = glcd_pkg::MASKW'(1) << uy[2:0];
    end

endmodule
